/* hdl/lkbs_pkg.sv */
// ============================================================================
// lkbs_pkg : shared definitions for the keyed byte scrambler
// Key size, derivation length, configuration register indices and the
// LFSR step used both for key derivation and for the keystream.
// ============================================================================
`default_nettype none

package lkbs_pkg;

  // Number of key bytes carried in a key and in a key header.
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned KEY_WIDTH   = KEY_BYTES * 8;
  // Header emission counter: counts KEY_BYTES header bytes and one data byte.
  localparam int unsigned HDR_CNT_W   = $clog2(KEY_BYTES + 1);
  // Shifts applied after the initial one when deriving the private key.
  localparam int unsigned DERIVE_SHIFTS = KEY_BYTES * 10;
  localparam int unsigned DERIVE_CNT_W  = $clog2(DERIVE_SHIFTS + 1);

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = KEY_WIDTH;

  // Configuration register indices.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRIVATE_SEED = 2'd0,
    CFG_USER_KEY     = 2'd1,
    CFG_DIRECTION    = 2'd2,
    CFG_KEY_HEADER   = 2'd3
  } cfg_index_t;

  // Direction codes.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // One right shift of the Fibonacci LFSR, taps at bits 63, 3, 2 and 0,
  // feedback entering at the top.
  function automatic logic [KEY_WIDTH-1:0] lfsr_next(input logic [KEY_WIDTH-1:0] s);
    logic fb;
    fb = s[KEY_WIDTH-1] ^ s[3] ^ s[2] ^ s[0];
    return {fb, s[KEY_WIDTH-1:1]};
  endfunction

endpackage

`default_nettype wire

/* hdl/lfsr_keyed_byte_scrambler.sv */
// ============================================================================
// lfsr_keyed_byte_scrambler : keyed byte stream scrambler / descrambler
// Scrambles or descrambles a byte stream with an LFSR keystream, a private
// key derived from a seed and a user key, with an optional key header.
// ============================================================================
// An accepted request waits in the input register, and its results pass on
//   into the output register.
// Throughput: one request per cycle unless the output or a key derivation
//   stalls. An encode request that starts a message with the key header
//   enabled holds the input register for eight header bytes and its data
//   byte; a decode header byte gives no result and never waits on the output.
// A write of the private seed stalls the input while the LFSR derives the
//   private key, one shift a cycle.
// Reset (rst_n low, synchronous) clears all state but the payload registers;
//   the private key resets to zero, which is what a zero seed derives to.
`default_nettype none

module lfsr_keyed_byte_scrambler
  import lkbs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_first_byte,
  input  wire logic                   in_message_end,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_is_header,
  output logic                        out_run_end,
  output logic                        out_end_of_message
);

  // --------------------------------------------------------------------------
  // Configuration registers and key derivation.
  // --------------------------------------------------------------------------
  logic [KEY_WIDTH-1:0]    user_key_r;
  logic                    direction_r;
  logic                    key_header_r;
  logic [KEY_WIDTH-1:0]    private_key_r;

  // The derivation engine runs the LFSR from the seed, one shift per cycle,
  // and holds off new requests until the private key has been written.
  logic [KEY_WIDTH-1:0]    derive_r;
  logic [DERIVE_CNT_W-1:0] derive_cnt_r;
  logic                    derive_busy_r;
  logic                    seed_write;

  assign seed_write = cfg_we && (cfg_index_t'(cfg_index) == CFG_PRIVATE_SEED);

  // --------------------------------------------------------------------------
  // Scrambler state.
  // --------------------------------------------------------------------------
  logic [KEY_WIDTH-1:0]    shift_r;
  logic [KEY_WIDTH-1:0]    recovered_key_r;
  logic [2:0]              byte_index_r;
  logic [HDR_CNT_W-1:0]    header_count_r;

  // --------------------------------------------------------------------------
  // Input register. A request sits here until its last result has moved into
  // the output register, or, for a decode header byte, until it is absorbed.
  // --------------------------------------------------------------------------
  logic                    s1_valid_r;
  logic [7:0]              s1_data_r;
  logic                    s1_first_r;
  logic                    s1_eom_r;
  logic [HDR_CNT_W-1:0]    hdr_cnt_r;

  // Output register.
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_is_header_r;
  logic                    out_run_end_r;
  logic                    out_eom_r;

  // --------------------------------------------------------------------------
  // Single pass datapath.
  // --------------------------------------------------------------------------
  logic                    out_ready;
  logic                    enc_header_run;
  logic                    hdr_phase;
  logic                    dec_consume;
  logic                    emit;
  logic                    done;
  logic                    s1_free;
  logic                    accept;
  logic [2:0]              eff_index;
  logic [HDR_CNT_W-1:0]    eff_hdr_count;
  logic [KEY_WIDTH-1:0]    base_shift;
  logic [KEY_WIDTH-1:0]    next_shift;
  logic [KEY_WIDTH-1:0]    sel_user_key;
  logic [7:0]              key_stream;
  logic [7:0]              priv_byte;
  logic [7:0]              user_byte;
  logic [15:0]             product;
  logic [7:0]              pu;
  logic [7:0]              data_result;
  logic [7:0]              header_result;
  logic [2:0]              hdr_sel;
  logic [KEY_WIDTH-1:0]    recovered_nxt;

  assign out_ready = !out_valid_r || !out_stall;

  // On encode with the header enabled, a first byte sends the key header
  // before its own data result.
  assign enc_header_run = s1_first_r && (direction_r == DIR_ENCODE) && key_header_r;
  assign hdr_phase      = enc_header_run && !hdr_cnt_r[HDR_CNT_W-1];

  // A first byte restarts the header count and the byte index.
  assign eff_hdr_count  = s1_first_r ? '0 : header_count_r;
  assign eff_index      = s1_first_r ? 3'd0 : byte_index_r;

  // On decode with the header enabled, the first key bytes of a message are
  // absorbed into the recovered key and give no result.
  assign dec_consume = s1_valid_r && (direction_r == DIR_DECODE) && key_header_r &&
                       !eff_hdr_count[HDR_CNT_W-1];

  assign emit    = s1_valid_r && !dec_consume && out_ready;
  assign done    = dec_consume || (emit && !hdr_phase);
  assign s1_free = !s1_valid_r || done;

  assign in_stall = derive_busy_r || !s1_free;
  assign accept   = in_valid && !in_stall;

  // Keystream: a first byte reloads the LFSR from the private key and shifts
  // it once, then every data byte shifts it again.
  assign base_shift = s1_first_r ? lfsr_next(private_key_r) : shift_r;
  assign next_shift = lfsr_next(base_shift);
  assign key_stream = next_shift[7:0];

  assign sel_user_key = ((direction_r == DIR_DECODE) && key_header_r) ?
                        recovered_key_r : user_key_r;
  assign priv_byte    = private_key_r[{eff_index, 3'b000} +: 8];
  assign user_byte    = sel_user_key[{eff_index, 3'b000} +: 8];
  assign product      = {8'd0, priv_byte} * {8'd0, user_byte};
  assign pu           = product[7:0];

  always_comb begin
    if (direction_r == DIR_ENCODE) begin
      data_result = (key_stream ^ s1_data_r ^ priv_byte) + pu;
    end else begin
      data_result = key_stream ^ (s1_data_r - pu) ^ priv_byte;
    end
  end

  // Header byte: private key byte XOR user key byte, in byte order.
  assign hdr_sel       = hdr_cnt_r[2:0];
  assign header_result = private_key_r[{hdr_sel, 3'b000} +: 8] ^
                         user_key_r[{hdr_sel, 3'b000} +: 8];

  // Recovered key: replace the byte selected by the header count.
  always_comb begin
    recovered_nxt = recovered_key_r;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (eff_hdr_count[2:0] == 3'(i)) begin
        recovered_nxt[8*i +: 8] = private_key_r[8*i +: 8] ^ s1_data_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control and state registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_key_r      <= '0;
      direction_r     <= DIR_ENCODE;
      key_header_r    <= 1'b0;
      private_key_r   <= '0;
      derive_cnt_r    <= '0;
      derive_busy_r   <= 1'b0;
      shift_r         <= '0;
      recovered_key_r <= '0;
      byte_index_r    <= '0;
      header_count_r  <= '0;
      s1_valid_r      <= 1'b0;
      hdr_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_PRIVATE_SEED: begin
            derive_cnt_r  <= DERIVE_CNT_W'(DERIVE_SHIFTS);
            derive_busy_r <= 1'b1;
          end
          CFG_USER_KEY:   user_key_r   <= cfg_data;
          CFG_DIRECTION:  direction_r  <= cfg_data[0];
          CFG_KEY_HEADER: key_header_r <= cfg_data[0];
          default: ;
        endcase
      end

      // The derivation keeps stepping while other registers are written, in
      // step with the shift register below.
      if (derive_busy_r && !seed_write) begin
        derive_cnt_r <= derive_cnt_r - 1'b1;
        if (derive_cnt_r == DERIVE_CNT_W'(1)) begin
          private_key_r <= lfsr_next(derive_r);
          derive_busy_r <= 1'b0;
        end
      end

      // Input register occupancy and header emission count.
      if (s1_free) begin
        s1_valid_r <= accept;
        hdr_cnt_r  <= '0;
      end else if (emit && hdr_phase) begin
        hdr_cnt_r <= hdr_cnt_r + 1'b1;
      end

      // Scrambler state moves on when a request completes.
      if (dec_consume) begin
        recovered_key_r <= recovered_nxt;
        header_count_r  <= eff_hdr_count + 1'b1;
        if (s1_first_r) begin
          shift_r      <= lfsr_next(private_key_r);
          byte_index_r <= '0;
        end
      end else if (emit && !hdr_phase) begin
        shift_r        <= next_shift;
        byte_index_r   <= eff_index + 3'd1;
        header_count_r <= eff_hdr_count;
      end

      if (out_ready) begin
        out_valid_r <= emit;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (seed_write) begin
      derive_r <= lfsr_next(cfg_data);
    end else if (derive_busy_r) begin
      derive_r <= lfsr_next(derive_r);
    end

    if (accept) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_eom_r   <= in_message_end;
    end

    if (emit) begin
      if (hdr_phase) begin
        out_byte_r      <= header_result;
        out_is_header_r <= 1'b1;
        out_run_end_r   <= 1'b0;
        out_eom_r       <= 1'b0;
      end else begin
        out_byte_r      <= data_result;
        out_is_header_r <= 1'b0;
        out_run_end_r   <= 1'b1;
        out_eom_r       <= s1_eom_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_is_header      = out_is_header_r;
  assign out_run_end        = out_run_end_r;
  assign out_end_of_message = out_eom_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A header byte never closes a run and never carries the message end.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_header_r |-> !out_run_end_r && !out_eom_r)
    else $error("header result marked as run end or message end");

  // The header counters never pass the key length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (header_count_r <= HDR_CNT_W'(KEY_BYTES)) && (hdr_cnt_r <= HDR_CNT_W'(KEY_BYTES)))
    else $error("header counter beyond key length");

  // No request is taken in the cycle after a seed write.
  assert property (@(posedge clk) disable iff (!rst_n)
    seed_write |=> in_stall)
    else $error("request accepted during key derivation");

  // A decode header byte leaves no result behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    dec_consume && !out_valid_r |=> !out_valid_r)
    else $error("result produced for an absorbed header byte");

endmodule

`default_nettype wire

/* sim/lfsr_keyed_byte_scrambler_tb.sv */
// ============================================================================
// lfsr_keyed_byte_scrambler_tb : self-checking bench for the byte scrambler
// Drives byte requests through the valid/stall input channel and predicts
// every result, including key header bytes. Each result leaving the block is
// compared field by field with the oldest prediction. Directed tests come
// first, then back-pressure and random traffic with several idling patterns.
// ============================================================================
`timescale 1ns / 100ps

module lfsr_keyed_byte_scrambler_tb
  import lkbs_pkg::*;
();

  // Generous ceiling on the run. Even a very slow correct run needs far fewer
  // cycles than this.
  localparam int CYCLE_LIMIT   = 200000;
  // Cycles allowed after the last predicted result before anything else is
  // done. A decode header byte gives no result, so the block may still be
  // busy when the queue has emptied.
  localparam int SETTLE_CYCLES = 16;

  // One predicted result, laid out like the result channel.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_header;
    logic       run_end;
    logic       end_of_message;
  } scrambled_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_PRIVATE_SEED;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_data_byte = 8'h00;
  logic                   in_first_byte = 1'b0;
  logic                   in_message_end = 1'b0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_is_header;
  logic                   out_run_end;
  logic                   out_end_of_message;

  // Predictor state: the bench's own copy of the configuration registers and
  // of the keystream state inside the block.
  logic [KEY_WIDTH-1:0]   m_private_key;
  logic [KEY_WIDTH-1:0]   m_user_key;
  logic                   m_direction;
  logic                   m_key_header;
  logic [KEY_WIDTH-1:0]   m_lfsr;
  logic [KEY_WIDTH-1:0]   m_recovered_key;
  logic [2:0]             m_byte_index;
  logic [3:0]             m_header_count;

  // Results predicted but not yet seen on the output, oldest first.
  scrambled_byte_t        pending_bytes[$];
  scrambled_byte_t        oldest;

  int                     mismatch_count = 0;
  int                     cycle_count = 0;

  // Idling controls, in percent per cycle. The hold-off counter lets a test
  // ask the receiver to stall for a long unbroken stretch.
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     hold_request = 0;
  int                     hold_left = 0;

  lfsr_keyed_byte_scrambler DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_message_end     (in_message_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_is_header      (out_is_header),
    .out_run_end        (out_run_end),
    .out_end_of_message (out_end_of_message)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lfsr_keyed_byte_scrambler test failed");
      $finish;
    end
  end

  // Receiver. A hold-off request from a test takes priority over the random
  // stalls and is counted down here, one cycle per edge.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker. Values read here are those present just before the edge,
  // so a result counts exactly when the block sees it accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h is_header %0b", out_byte, out_is_header);
        mismatch_count++;
      end else begin
        oldest = pending_bytes.pop_front();
        if (out_byte !== oldest.byte_val) begin
          $error("out_byte: expected %02h, actual %02h", oldest.byte_val, out_byte);
          mismatch_count++;
        end
        if (out_is_header !== oldest.is_header) begin
          $error("is_header: expected %0b, actual %0b", oldest.is_header, out_is_header);
          mismatch_count++;
        end
        if (out_run_end !== oldest.run_end) begin
          $error("run_end: expected %0b, actual %0b", oldest.run_end, out_run_end);
          mismatch_count++;
        end
        if (out_end_of_message !== oldest.end_of_message) begin
          $error("end_of_message: expected %0b, actual %0b",
                 oldest.end_of_message, out_end_of_message);
          mismatch_count++;
        end
      end
    end
  end

  // One right shift of the 64-bit Fibonacci register; the feedback from
  // bits 63, 3, 2 and 0 enters at the top.
  function automatic logic [KEY_WIDTH-1:0] lfsr_advance(input logic [KEY_WIDTH-1:0] s);
    logic feedback;
    feedback = s[63] ^ s[3] ^ s[2] ^ s[0];
    return {feedback, s[63:1]};
  endfunction

  // The private key is the seed after one shift and then eighty more.
  function automatic logic [KEY_WIDTH-1:0] derive_private_key(input logic [KEY_WIDTH-1:0] seed);
    logic [KEY_WIDTH-1:0] s;
    s = lfsr_advance(seed);
    for (int i = 0; i < DERIVE_SHIFTS; i++) s = lfsr_advance(s);
    return s;
  endfunction

  // Random key word with a fair share of the two extremes.
  function automatic logic [KEY_WIDTH-1:0] pick_key_word();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Works out what one accepted request produces and queues it.
  task automatic predict_request(input logic [7:0] d, input logic first, input logic eom);
    logic [7:0]           ks;
    logic [7:0]           pk;
    logic [7:0]           uk;
    logic [7:0]           coded;
    logic [KEY_WIDTH-1:0] active_user_key;
    scrambled_byte_t      r;
    if (first) begin
      m_lfsr = lfsr_advance(m_private_key);
      m_byte_index = '0;
      m_header_count = '0;
      // On encode the key header goes out ahead of the first data byte.
      if (m_direction == DIR_ENCODE && m_key_header) begin
        for (int i = 0; i < KEY_BYTES; i++) begin
          r.byte_val = m_private_key[i*8 +: 8] ^ m_user_key[i*8 +: 8];
          r.is_header = 1'b1;
          r.run_end = 1'b0;
          r.end_of_message = 1'b0;
          pending_bytes.push_back(r);
        end
      end
    end
    if (m_direction == DIR_DECODE && m_key_header && m_header_count < KEY_BYTES) begin
      // A header byte on decode recovers one user key byte and is swallowed,
      // together with any message end flag it carries.
      m_recovered_key[int'(m_header_count)*8 +: 8] =
        m_private_key[int'(m_header_count)*8 +: 8] ^ d;
      m_header_count++;
    end else begin
      active_user_key = (m_direction == DIR_DECODE && m_key_header) ? m_recovered_key
                                                                    : m_user_key;
      m_lfsr = lfsr_advance(m_lfsr);
      ks = m_lfsr[7:0];
      pk = m_private_key[int'(m_byte_index)*8 +: 8];
      uk = active_user_key[int'(m_byte_index)*8 +: 8];
      if (m_direction == DIR_ENCODE) coded = (ks ^ d ^ pk) + 8'(pk * uk);
      else                           coded = ks ^ (d - 8'(pk * uk)) ^ pk;
      m_byte_index++;
      r.byte_val = coded;
      r.is_header = 1'b0;
      r.run_end = 1'b1;
      r.end_of_message = eom;
      pending_bytes.push_back(r);
    end
  endtask

  // Writes one configuration register and mirrors it in the predictor. Only
  // called while the block is idle.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PRIVATE_SEED: m_private_key = derive_private_key(value);
      CFG_USER_KEY:     m_user_key = value;
      CFG_DIRECTION:    m_direction = value[0];
      CFG_KEY_HEADER:   m_key_header = value[0];
      default:          ;
    endcase
  endtask

  // Offers one byte request and holds it until the block takes it. Valid is
  // left high on return so that back-to-back requests need no gap; any idle
  // cycles are inserted before the next request is raised.
  task automatic offer_byte(input logic [7:0] d, input logic first, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_first_byte <= first;
    in_message_end <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(d, first, eom);
  endtask

  // Lowers the request and waits until every predicted result has arrived,
  // then a little longer for swallowed header bytes to leave the block.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Straight after reset the private key is zero, so the keystream register
  // starts all zero. Bytes sent before any first byte run on from the reset
  // state. An explicit zero seed must give the same zero key.
  task automatic test_zero_seed();
    offer_byte(8'h5A, 1'b0, 1'b0);
    offer_byte(8'hFF, 1'b1, 1'b0);
    offer_byte(8'h00, 1'b0, 1'b1);
    wait_drain();
    write_reg(CFG_PRIVATE_SEED, '0);
    write_reg(CFG_USER_KEY, '1);
    offer_byte(8'hFF, 1'b1, 1'b1);
    wait_drain();
  endtask

  // Encode with the key header: a first byte gives eight header bytes and
  // then its data byte. A later byte of the same message gets no header.
  task automatic test_encode_header();
    write_reg(CFG_PRIVATE_SEED, '1);
    write_reg(CFG_USER_KEY, 64'h0123_4567_89AB_CDEF);
    write_reg(CFG_DIRECTION, {63'd0, DIR_ENCODE});
    write_reg(CFG_KEY_HEADER, 64'd1);
    offer_byte(8'hFF, 1'b1, 1'b0);
    offer_byte(8'h00, 1'b0, 1'b1);
    // A one-byte message: first and end on the same request.
    offer_byte(8'h80, 1'b1, 1'b1);
    wait_drain();
  endtask

  // Decode with the key header: the first eight bytes rebuild the user key
  // and give nothing back, an end flag among them is dropped, and the data
  // that follows is decoded with the recovered key.
  task automatic test_decode_header();
    write_reg(CFG_PRIVATE_SEED, {$urandom, $urandom});
    write_reg(CFG_DIRECTION, {63'd0, DIR_DECODE});
    write_reg(CFG_KEY_HEADER, 64'd1);
    for (int i = 0; i < KEY_BYTES; i++) begin
      offer_byte((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), i == 0, i == 5);
    end
    offer_byte(8'h00, 1'b0, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b0);
    offer_byte(8'h7E, 1'b0, 1'b1);
    wait_drain();
  endtask

  // Decode without a header uses the configured user key directly.
  task automatic test_decode_plain();
    write_reg(CFG_USER_KEY, {$urandom, $urandom});
    write_reg(CFG_KEY_HEADER, {$urandom, 31'h7FFF_FFFF, 1'b0});
    offer_byte(8'hA5, 1'b1, 1'b0);
    offer_byte(8'hFF, 1'b0, 1'b0);
    offer_byte(8'h00, 1'b0, 1'b1);
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the block fills and stalls its input. The sender then pauses until every
  // result is in, and a header run is pushed through a second hold-off.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_DIRECTION, {63'd0, DIR_ENCODE});
    write_reg(CFG_KEY_HEADER, 64'd0);
    hold_request = 60;
    for (int i = 0; i < 20; i++) offer_byte(8'($urandom), i == 0, i == 19);
    wait_drain();
    write_reg(CFG_KEY_HEADER, 64'd1);
    hold_request = 40;
    for (int i = 0; i < 4; i++) offer_byte(8'($urandom), i == 0, i == 3);
    wait_drain();
  endtask

  // Random traffic in four idling patterns; in each, every combination of
  // direction and key header is run with fresh keys. Most messages are well
  // formed; the rest carry random first and end flags. Messages in decode
  // header mode are long enough to get past the header.
  task automatic test_random_traffic();
    int  sent;
    int  len;
    int  mode;
    bit  broken;
    bit  dir;
    bit  hdr;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (mode = 0; mode < 4; mode++) begin
        dir = mode[0];
        hdr = mode[1];
        write_reg(CFG_PRIVATE_SEED, pick_key_word());
        write_reg(CFG_USER_KEY, pick_key_word());
        write_reg(CFG_DIRECTION, {$urandom, 31'($urandom), dir});
        write_reg(CFG_KEY_HEADER, {$urandom, 31'($urandom), hdr});
        sent = 0;
        while (sent < 5) begin
          broken = ($urandom_range(99) < 15);
          len = (dir && hdr) ? $urandom_range(9, 14) : $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            if (broken) offer_byte(8'($urandom), 1'($urandom_range(1)),
                                   1'($urandom_range(1)));
            else        offer_byte(8'($urandom), j == 0, j == len - 1);
            sent++;
          end
        end
        // Leaves the block idle, sometimes mid-message, before the next writes.
        wait_drain();
      end
    end
  endtask

  initial begin
    m_private_key = '0;
    m_user_key = '0;
    m_direction = DIR_ENCODE;
    m_key_header = 1'b0;
    m_lfsr = '0;
    m_recovered_key = '0;
    m_byte_index = '0;
    m_header_count = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_seed();
    test_encode_header();
    test_decode_header();
    test_decode_plain();
    test_back_pressure();
    test_random_traffic();

    wait_drain();
    if (mismatch_count == 0) begin
      $display("lfsr_keyed_byte_scrambler test passed");
    end else begin
      $display("lfsr_keyed_byte_scrambler test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lkbs_pkg.sv
hdl/lfsr_keyed_byte_scrambler.sv
sim/lfsr_keyed_byte_scrambler_tb.sv
